FILE: design/dtrm_pkg.sv
// ----------------------------------------------------------------------------
// dtrm_pkg
// Shared types and constants for the dirty tile rectangle marker.
// ----------------------------------------------------------------------------
package dtrm_pkg;

    // default grid geometry
    localparam int DEF_TILE_COLS  = 32;
    localparam int DEF_TILE_ROWS  = 16;
    localparam int DEF_TILE_SHIFT = 4;

    // pixel coordinate width and the widened signed width used for compares
    localparam int PX_W  = 16;
    localparam int EXT_W = 18;

    // width that holds any tile index from the request plus the grid size
    localparam int IDX_EXT_W = 9;

    // request modes
    localparam logic [1:0] MODE_MARK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]             mode;
        logic signed [PX_W-1:0] left_px;
        logic signed [PX_W-1:0] top_px;
        logic signed [PX_W-1:0] right_px;
        logic signed [PX_W-1:0] bottom_px;
        logic [4:0]             tile_col;
        logic [3:0]             tile_row;
    } in_t;

    typedef struct packed {
        logic visible;
        logic tile_dirty;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_MARK_LAST,
        ST_READ_WAIT,
        ST_RESULT
    } state_t;

endpackage

FILE: design/dtrm_rect_clip.sv
// ----------------------------------------------------------------------------
// dtrm_rect_clip
// Converts a pixel rectangle to tile coordinates and clips it to the grid.
// ----------------------------------------------------------------------------
module dtrm_rect_clip #(
    parameter int TILE_COLS  = dtrm_pkg::DEF_TILE_COLS,
    parameter int TILE_ROWS  = dtrm_pkg::DEF_TILE_ROWS,
    parameter int TILE_SHIFT = dtrm_pkg::DEF_TILE_SHIFT,
    localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1,
    localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1
) (
    input  logic signed [dtrm_pkg::PX_W-1:0] left_px,
    input  logic signed [dtrm_pkg::PX_W-1:0] top_px,
    input  logic signed [dtrm_pkg::PX_W-1:0] right_px,
    input  logic signed [dtrm_pkg::PX_W-1:0] bottom_px,
    output logic                             on_grid,
    output logic                             rows_empty,
    output logic [COL_W-1:0]                 col_first,
    output logic [COL_W-1:0]                 col_last,
    output logic [ROW_W-1:0]                 row_first,
    output logic [ROW_W-1:0]                 row_last
);

    localparam int EW = dtrm_pkg::EXT_W;
    localparam logic signed [EW-1:0] COLS_S = EW'(TILE_COLS);
    localparam logic signed [EW-1:0] ROWS_S = EW'(TILE_ROWS);

    logic signed [dtrm_pkg::PX_W-1:0] tl_c, tl_r, br_c, br_r;
    logic signed [EW-1:0] c1, r1, c2, r2;
    logic signed [EW-1:0] c1_clip, r1_clip, c2_clip, r2_clip;

    // arithmetic shift rounds toward minus infinity
    assign tl_c = left_px >>> TILE_SHIFT;
    assign tl_r = top_px >>> TILE_SHIFT;
    assign br_c = right_px >>> TILE_SHIFT;
    assign br_r = bottom_px >>> TILE_SHIFT;

    assign c1 = $signed({{(EW-dtrm_pkg::PX_W){tl_c[dtrm_pkg::PX_W-1]}}, tl_c});
    assign r1 = $signed({{(EW-dtrm_pkg::PX_W){tl_r[dtrm_pkg::PX_W-1]}}, tl_r});
    assign c2 = $signed({{(EW-dtrm_pkg::PX_W){br_c[dtrm_pkg::PX_W-1]}}, br_c});
    assign r2 = $signed({{(EW-dtrm_pkg::PX_W){br_r[dtrm_pkg::PX_W-1]}}, br_r});

    // wholly off the grid when any edge lies past the opposite grid border
    assign on_grid = !((c1 >= COLS_S) || (r1 >= ROWS_S) || (c2 < 0) || (r2 < 0));

    // clip to the grid
    assign c1_clip = (c1 < 0) ? '0 : c1;
    assign r1_clip = (r1 < 0) ? '0 : r1;
    assign c2_clip = (c2 >= COLS_S) ? (COLS_S - EW'(1)) : c2;
    assign r2_clip = (r2 >= ROWS_S) ? (ROWS_S - EW'(1)) : r2;

    assign rows_empty = (r1_clip > r2_clip);

    assign col_first = c1_clip[COL_W-1:0];
    assign col_last  = c2_clip[COL_W-1:0];
    assign row_first = r1_clip[ROW_W-1:0];
    assign row_last  = r2_clip[ROW_W-1:0];

endmodule

FILE: design/dtrm_map_ram.sv
// ----------------------------------------------------------------------------
// dtrm_map_ram
// Row-wide dirty map storage with per-row valid bits for instant clearing.
// ----------------------------------------------------------------------------
module dtrm_map_ram #(
    parameter int TILE_COLS = dtrm_pkg::DEF_TILE_COLS,
    parameter int TILE_ROWS = dtrm_pkg::DEF_TILE_ROWS,
    localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear_all,
    input  logic                 wr_en,
    input  logic [ROW_W-1:0]     wr_addr,
    input  logic [TILE_COLS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ROW_W-1:0]     rd_addr,
    output logic [TILE_COLS-1:0] rd_data
);

    logic [TILE_COLS-1:0] mem [TILE_ROWS];
    logic [TILE_ROWS-1:0] row_valid_reg;
    logic [TILE_COLS-1:0] rd_word_reg;
    logic                 rd_valid_reg;

    // storage array, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // row valid bits: a row never written since the last clear reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (clear_all) begin
                row_valid_reg <= '0;
            end else if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

FILE: design/dirty_tile_rect_marker_top.sv
// ----------------------------------------------------------------------------
// dirty_tile_rect_marker_top
// Dirty tile map with rectangle marking, single tile read and clear-all.
// ----------------------------------------------------------------------------
// The map is held one tile row per memory word. A mark request walks the
// covered tile rows one per cycle in a read-modify-write pipeline (read row
// n while row n-1 is written back), then passes ST_MARK_LAST for the last
// write-back and ST_RESULT. A read passes ST_READ_WAIT for the registered
// memory read, then ST_RESULT; a clear, an unused mode and an empty or
// off-grid rectangle go straight to ST_RESULT. Clearing is immediate through
// per-row valid bits, also after reset. One request is in flight at a time;
// a finished result sits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
module dirty_tile_rect_marker_top #(
    parameter int TILE_COLS  = dtrm_pkg::DEF_TILE_COLS,
    parameter int TILE_ROWS  = dtrm_pkg::DEF_TILE_ROWS,
    parameter int TILE_SHIFT = dtrm_pkg::DEF_TILE_SHIFT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dtrm_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dtrm_pkg::out_t m_data
);

    localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int XW    = dtrm_pkg::IDX_EXT_W;

    dtrm_pkg::state_t state_reg, state_next;

    logic                 accept;
    logic                 on_grid, rows_empty;
    logic [COL_W-1:0]     col_first, col_last;
    logic [ROW_W-1:0]     row_first, row_last;

    logic [COL_W-1:0]     c1_reg, c2_reg;
    logic [ROW_W-1:0]     row_cnt_reg, r2_reg;
    logic                 wr_pend_reg;
    logic [ROW_W-1:0]     wr_row_reg;
    logic [COL_W-1:0]     col_idx_reg;
    logic                 addr_ok_reg;
    dtrm_pkg::out_t       res_reg;
    logic                 m_valid_reg;
    dtrm_pkg::out_t       m_data_reg;

    logic [XW-1:0]        col_ext, row_ext;
    logic                 addr_ok;
    logic [TILE_COLS-1:0] col_mask;
    logic [TILE_COLS-1:0] rd_data;

    logic                 ram_rd_en, ram_clear;
    logic [ROW_W-1:0]     ram_rd_addr;
    logic                 out_free;
    logic                 mark_go;

    // corner conversion and clipping
    dtrm_rect_clip #(
        .TILE_COLS (TILE_COLS),
        .TILE_ROWS (TILE_ROWS),
        .TILE_SHIFT(TILE_SHIFT)
    ) u_clip (
        .left_px   (s_data.left_px),
        .top_px    (s_data.top_px),
        .right_px  (s_data.right_px),
        .bottom_px (s_data.bottom_px),
        .on_grid   (on_grid),
        .rows_empty(rows_empty),
        .col_first (col_first),
        .col_last  (col_last),
        .row_first (row_first),
        .row_last  (row_last)
    );

    // dirty map storage
    dtrm_map_ram #(
        .TILE_COLS(TILE_COLS),
        .TILE_ROWS(TILE_ROWS)
    ) u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear_all(ram_clear),
        .wr_en    (wr_pend_reg),
        .wr_addr  (wr_row_reg),
        .wr_data  (rd_data | col_mask),
        .rd_en    (ram_rd_en),
        .rd_addr  (ram_rd_addr),
        .rd_data  (rd_data)
    );

    // read address decode
    assign col_ext = XW'(s_data.tile_col);
    assign row_ext = XW'(s_data.tile_row);
    assign addr_ok = (col_ext < XW'(TILE_COLS)) && (row_ext < XW'(TILE_ROWS));

    // column mask of the clipped rectangle
    always_comb begin
        for (int i = 0; i < TILE_COLS; i++) begin
            col_mask[i] = (COL_W'(i) >= c1_reg) && (COL_W'(i) <= c2_reg);
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign mark_go  = on_grid && !rows_empty;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dtrm_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.mode == dtrm_pkg::MODE_MARK && mark_go) begin
                        state_next = dtrm_pkg::ST_MARK;
                    end else if (s_data.mode == dtrm_pkg::MODE_READ) begin
                        state_next = dtrm_pkg::ST_READ_WAIT;
                    end else begin
                        state_next = dtrm_pkg::ST_RESULT;
                    end
                end
            end
            dtrm_pkg::ST_MARK: begin
                if (row_cnt_reg == r2_reg) begin
                    state_next = dtrm_pkg::ST_MARK_LAST;
                end
            end
            dtrm_pkg::ST_MARK_LAST: state_next = dtrm_pkg::ST_RESULT;
            dtrm_pkg::ST_READ_WAIT: state_next = dtrm_pkg::ST_RESULT;
            dtrm_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = dtrm_pkg::ST_IDLE;
                end
            end
            default: state_next = dtrm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = row_cnt_reg;
        ram_clear   = 1'b0;
        case (state_reg)
            dtrm_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                ram_rd_addr = row_ext[ROW_W-1:0];
                ram_rd_en   = s_valid && (s_data.mode == dtrm_pkg::MODE_READ);
                ram_clear   = s_valid && (s_data.mode == dtrm_pkg::MODE_CLEAR);
            end
            dtrm_pkg::ST_MARK: begin
                ram_rd_en = 1'b1;
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dtrm_pkg::ST_IDLE;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_pend_reg <= (state_reg == dtrm_pkg::ST_MARK);
            if (state_reg == dtrm_pkg::ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        wr_row_reg <= row_cnt_reg;
        if (accept) begin
            c1_reg              <= col_first;
            c2_reg              <= col_last;
            row_cnt_reg         <= row_first;
            r2_reg              <= row_last;
            col_idx_reg         <= col_ext[COL_W-1:0];
            addr_ok_reg         <= addr_ok;
            res_reg.visible     <= (s_data.mode == dtrm_pkg::MODE_MARK) && on_grid;
            res_reg.tile_dirty  <= 1'b0;
        end else if (state_reg == dtrm_pkg::ST_MARK) begin
            row_cnt_reg <= ROW_W'(row_cnt_reg + 1'b1);
        end else if (state_reg == dtrm_pkg::ST_READ_WAIT) begin
            res_reg.tile_dirty <= addr_ok_reg && rd_data[col_idx_reg];
        end
        if (state_reg == dtrm_pkg::ST_RESULT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
